### rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int unsigned POS_W   = 11;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned DEPTH_D = 1024;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // word travelling along the cell chain: an element or the result token
  typedef struct packed {
    logic                    vld;
    logic                    is_tok;
    logic signed [VAL_W-1:0] key;
    logic [CNT_W-1:0]        cnt;
  } chain_word_t;

endpackage

### rtl/rmq_if.sv
interface rmq_in_if;
  import rmq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [POS_W-1:0]        first_pos;
  logic [POS_W-1:0]        last_pos;
  logic signed [VAL_W-1:0] data_value;

  modport source (output valid, command, first_pos, last_pos, data_value, input ready);
  modport sink   (input valid, command, first_pos, last_pos, data_value, output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] mode_value;
  logic [CNT_W-1:0]        mode_count;

  modport source (output valid, mode_value, mode_count, input ready);
  modport sink   (input valid, mode_value, mode_count, output ready);
endinterface

### rtl/range_mode_query_core.sv
// Range mode engine over a store of ARRAY_DEPTH signed 32-bit elements.
// Input channel in_word: command write stores data_value at 1-based
// first_pos (out-of-range positions dropped) and returns nothing; command
// query returns one word on out_word with the most frequent value in
// [first_pos, last_pos] (clipped to the array) and its count, the smallest
// value winning ties; an empty range returns value 0, count 0.
// A query of n elements streams them out of the element memory, one read
// per cycle, into a chain of ARRAY_DEPTH cells that each tally one
// distinct value; a token then sweeps the chain, picking the best tally
// and freeing the cells. The result word is registered and becomes valid
// once the token has left the last cell of the chain.
// One query is in flight at a time; in_word.ready is low while it runs
// and while a result waits on a stalled receiver.
// Reset clears control state and the cells; memory contents are undefined
// until written.
module range_mode_query_core #(
  parameter int unsigned ARRAY_DEPTH = rmq_pkg::DEPTH_D
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_word,
  rmq_out_if.source out_word
);
  import rmq_pkg::*;

  localparam int unsigned AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_TOK, S_DRAIN} state_t;

  state_t                  state_r, state_nxt;
  logic [POS_W-1:0]        ptr_r, ptr_nxt;
  logic [POS_W-1:0]        hi_r, hi_nxt;
  logic                    el_iss_r, el_iss_nxt;
  logic                    tok_iss_r, tok_iss_nxt;
  logic                    out_v_r, out_v_nxt;
  logic signed [VAL_W-1:0] res_val_r;
  logic [CNT_W-1:0]        res_cnt_r;

  logic signed [VAL_W-1:0] mem [ARRAY_DEPTH];
  logic signed [VAL_W-1:0] mem_q_r;

  logic [31:0]      lo_ext, hi_ext;
  logic             accept, do_write, rd_en;
  logic [POS_W-1:0] rd_pos;

  chain_word_t head_w;
  chain_word_t link [ARRAY_DEPTH+1];

  assign accept = in_word.valid && in_word.ready;
  assign in_word.ready = (state_r == S_IDLE) && !out_v_r;

  // clip query bounds to the array
  always_comb begin
    lo_ext = (in_word.first_pos == '0) ? 32'd1 : 32'(in_word.first_pos);
    hi_ext = (32'(in_word.last_pos) > ARRAY_DEPTH) ? ARRAY_DEPTH : 32'(in_word.last_pos);
  end

  assign do_write = accept && (in_word.command == CMD_WRITE) &&
                    (in_word.first_pos != '0) && (32'(in_word.first_pos) <= ARRAY_DEPTH);
  assign rd_en  = (state_r == S_READ);
  assign rd_pos = ptr_r - POS_W'(1);

  // element memory
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[AW'(in_word.first_pos - POS_W'(1))] <= in_word.data_value;
    end
    if (rd_en) begin
      mem_q_r <= mem[AW'(rd_pos)];
    end
  end

  // query sequencer
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    hi_nxt      = hi_r;
    el_iss_nxt  = 1'b0;
    tok_iss_nxt = 1'b0;
    out_v_nxt   = out_v_r;
    if (out_word.valid && out_word.ready) begin
      out_v_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_word.command == CMD_QUERY) begin
          ptr_nxt = POS_W'(lo_ext);
          hi_nxt  = POS_W'(hi_ext);
          state_nxt = (lo_ext <= hi_ext) ? S_READ : S_TOK;
        end
      end
      S_READ: begin
        el_iss_nxt = 1'b1;
        ptr_nxt    = ptr_r + POS_W'(1);
        if (ptr_r == hi_r) begin
          state_nxt = S_TOK;
        end
      end
      S_TOK: begin
        tok_iss_nxt = 1'b1;
        state_nxt   = S_DRAIN;
      end
      S_DRAIN: begin
        if (link[ARRAY_DEPTH].vld && link[ARRAY_DEPTH].is_tok) begin
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      el_iss_r  <= 1'b0;
      tok_iss_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      el_iss_r  <= el_iss_nxt;
      tok_iss_r <= tok_iss_nxt;
      out_v_r   <= out_v_nxt;
    end
    ptr_r <= ptr_nxt;
    hi_r  <= hi_nxt;
    if (state_r == S_DRAIN && link[ARRAY_DEPTH].vld && link[ARRAY_DEPTH].is_tok) begin
      res_val_r <= link[ARRAY_DEPTH].key;
      res_cnt_r <= link[ARRAY_DEPTH].cnt;
    end
  end

  // chain head: element from memory, or a fresh token
  always_comb begin
    head_w.vld    = el_iss_r || tok_iss_r;
    head_w.is_tok = tok_iss_r;
    head_w.key    = el_iss_r ? mem_q_r : '0;
    head_w.cnt    = '0;
  end

  assign link[0] = head_w;

  for (genvar g = 0; g < ARRAY_DEPTH; g++) begin : g_cell
    rmq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .in_w  (link[g]),
      .out_w (link[g+1])
    );
  end

  assign out_word.valid      = out_v_r;
  assign out_word.mode_value = res_val_r;
  assign out_word.mode_count = res_cnt_r;

endmodule

### rtl/rmq_cell.sv
module rmq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmq_pkg::chain_word_t in_w,
  output rmq_pkg::chain_word_t out_w
);
  import rmq_pkg::*;

  logic                    own_v_r,   own_v_nxt;
  logic signed [VAL_W-1:0] own_key_r, own_key_nxt;
  logic [CNT_W-1:0]        own_cnt_r, own_cnt_nxt;
  chain_word_t             out_r,     out_nxt;

  always_comb begin
    own_v_nxt   = own_v_r;
    own_key_nxt = own_key_r;
    own_cnt_nxt = own_cnt_r;
    out_nxt     = in_w;
    if (in_w.vld && !in_w.is_tok) begin
      // element: count it here if it matches or the cell is free
      if (own_v_r && own_key_r == in_w.key) begin
        own_cnt_nxt = own_cnt_r + CNT_W'(1);
        out_nxt.vld = 1'b0;
      end else if (!own_v_r) begin
        own_v_nxt   = 1'b1;
        own_key_nxt = in_w.key;
        own_cnt_nxt = CNT_W'(1);
        out_nxt.vld = 1'b0;
      end
    end else if (in_w.vld && in_w.is_tok) begin
      // token: merge own tally into the running best, then free the cell
      if (own_v_r && (own_cnt_r > in_w.cnt ||
                      (own_cnt_r == in_w.cnt && own_key_r < in_w.key))) begin
        out_nxt.key = own_key_r;
        out_nxt.cnt = own_cnt_r;
      end
      own_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_v_r   <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      own_v_r   <= own_v_nxt;
      out_r.vld <= out_nxt.vld;
    end
    own_key_r    <= own_key_nxt;
    own_cnt_r    <= own_cnt_nxt;
    out_r.is_tok <= out_nxt.is_tok;
    out_r.key    <= out_nxt.key;
    out_r.cnt    <= out_nxt.cnt;
  end

  assign out_w = out_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rmq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned HOT_SPAN = 96;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH_D + 64;

  typedef struct {
    logic                    cmd;
    logic [POS_W-1:0]        first;
    logic [POS_W-1:0]        last;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    logic signed [VAL_W-1:0] typed_val;
    logic [CNT_W-1:0]        typed_cnt;
  } stim_row_t;

  typedef struct {
    logic signed [VAL_W-1:0] val;
    logic [CNT_W-1:0]        cnt;
  } mode_word_t;

  logic clk;
  logic rst_n;

  rmq_in_if  in_if();
  rmq_out_if out_if();

  range_mode_query_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_if),
    .out_word(out_if)
  );

  // shadow copy of the element memory
  logic signed [VAL_W-1:0] shadow_mem [1:DEPTH_D];
  bit                      shadow_set [1:DEPTH_D];

  mode_word_t  pending_modes[$];
  stim_row_t   dir_rows[$];
  int unsigned cycles;
  int unsigned err_cnt;
  int unsigned n_writes, n_queries, n_checked;
  int unsigned tx_idle_pct, rx_idle_pct;
  bit          rx_hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mode of shadow_mem over a clipped range, smallest value on ties
  function automatic mode_word_t range_mode(logic [POS_W-1:0] first, logic [POS_W-1:0] last);
    mode_word_t m;
    int lo, hi, c;
    lo = (first < 1) ? 1 : int'(first);
    hi = (last > DEPTH_D) ? DEPTH_D : int'(last);
    m.val = '0;
    m.cnt = '0;
    for (int i = lo; i <= hi; i++) begin
      c = 0;
      for (int j = lo; j <= hi; j++)
        if (shadow_mem[j] == shadow_mem[i]) c++;
      if (c > m.cnt || (c == m.cnt && shadow_mem[i] < m.val)) begin
        m.val = shadow_mem[i];
        m.cnt = c[CNT_W-1:0];
      end
    end
    return m;
  endfunction

  // drive one word; returns after it was accepted
  task automatic send_word(stim_row_t r);
    mode_word_t m;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      in_if.command = 1'($urandom);
      in_if.first_pos = POS_W'($urandom);
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.command    = r.cmd;
    in_if.first_pos  = r.first;
    in_if.last_pos   = r.last;
    in_if.data_value = r.val;
    do @(posedge clk); while (!in_if.ready);
    if (r.cmd == CMD_WRITE) begin
      n_writes++;
      if (r.first >= 1 && r.first <= DEPTH_D) begin
        shadow_mem[r.first] = r.val;
        shadow_set[r.first] = 1'b1;
      end
    end else begin
      n_queries++;
      if (r.typed) begin
        m.val = r.typed_val;
        m.cnt = r.typed_cnt;
      end else begin
        m = range_mode(r.first, r.last);
      end
      pending_modes.push_back(m);
    end
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  function automatic stim_row_t make_row(logic cmd, int first, int last, logic [31:0] v);
    stim_row_t r;
    r.cmd = cmd;
    r.first = first[POS_W-1:0];
    r.last = last[POS_W-1:0];
    r.val = v;
    r.typed = 1'b0;
    r.typed_val = '0;
    r.typed_cnt = '0;
    return r;
  endfunction

  function automatic stim_row_t known(stim_row_t r, logic [31:0] v, int c);
    r.typed = 1'b1;
    r.typed_val = v;
    r.typed_cnt = c[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                              32'd5, 32'hFFFF_FFF9, 32'd7, 32'd1};
    if ($urandom_range(99) < 65) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // random word: mostly writes and well-formed queries over written cells
  function automatic stim_row_t random_row();
    stim_row_t r;
    int sel, lo, hi, span;
    sel = $urandom_range(99);
    if (sel < 45) begin
      if ($urandom_range(9) < 7) lo = $urandom_range(HOT_SPAN, 1);
      else if ($urandom_range(1)) lo = $urandom_range(DEPTH_D, 1);
      else lo = $urandom_range(2047);
      return make_row(CMD_WRITE, lo, $urandom, pick_value());
    end
    if (sel < 90) begin
      for (int t = 0; t < 40; t++) begin
        lo = (t < 30) ? $urandom_range(HOT_SPAN, 1) : $urandom_range(DEPTH_D, 1);
        if (shadow_set[lo]) begin
          hi = lo;
          span = ($urandom_range(9) < 8) ? $urandom_range(16) : $urandom_range(DEPTH_D);
          while (hi < DEPTH_D && shadow_set[hi+1] && hi - lo < span) hi++;
          r = make_row(CMD_QUERY, lo, hi, $urandom);
          if (lo == 1 && $urandom_range(1)) r.first = '0;
          if (hi == DEPTH_D && $urandom_range(1)) r.last = POS_W'($urandom_range(2047, DEPTH_D));
          return r;
        end
      end
    end
    // empty range with arbitrary bounds
    lo = $urandom_range(2047, 1);
    hi = $urandom_range(lo - 1);
    if ($urandom_range(3) == 0) hi = $urandom_range(2047, DEPTH_D + 1);
    if (hi >= lo) lo = hi + 1 > 2047 ? 2047 : hi + 1;
    if (hi >= lo) hi = lo - 1;
    return make_row(CMD_QUERY, lo, hi, $urandom);
  endfunction

  // receiver: ready at the falling edge, long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
    end else if (rx_hold_req) begin
      out_if.ready = 1'b0;
      for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      rx_hold_req = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    mode_word_t m;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_modes.size() == 0) begin
        $error("result word with nothing pending: value %0d count %0d",
               out_if.mode_value, out_if.mode_count);
        err_cnt++;
      end else begin
        m = pending_modes.pop_front();
        n_checked++;
        if (out_if.mode_value !== m.val) begin
          $error("mode_value expected %0d actual %0d", m.val, out_if.mode_value);
          err_cnt++;
        end
        if (out_if.mode_count !== m.cnt) begin
          $error("mode_count expected %0d actual %0d", m.cnt, out_if.mode_count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned wait_cnt;
    cycles = 0;
    err_cnt = 0;
    n_writes = 0;
    n_queries = 0;
    n_checked = 0;
    rx_hold_req = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 87;
    for (int i = 1; i <= DEPTH_D; i++) begin
      shadow_mem[i] = '0;
      shadow_set[i] = 1'b0;
    end
    in_if.valid = 1'b0;
    in_if.command = CMD_WRITE;
    in_if.first_pos = '0;
    in_if.last_pos = '0;
    in_if.data_value = '0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, clipping, dropped writes, empty ranges, ties
    dir_rows.push_back(make_row(CMD_WRITE, 1, 0, 32'h8000_0000));
    dir_rows.push_back(make_row(CMD_WRITE, 2, 2047, 32'h7FFF_FFFF));
    dir_rows.push_back(make_row(CMD_WRITE, 3, 0, 32'h0));
    dir_rows.push_back(make_row(CMD_WRITE, 4, 0, 32'hFFFF_FFFF));
    dir_rows.push_back(make_row(CMD_WRITE, 5, 0, 32'h7FFF_FFFF));
    dir_rows.push_back(make_row(CMD_WRITE, 6, 0, 32'd7));
    dir_rows.push_back(make_row(CMD_WRITE, 7, 0, 32'hFFFF_FFF9));
    dir_rows.push_back(make_row(CMD_WRITE, 1024, 0, 32'd12345));
    dir_rows.push_back(make_row(CMD_WRITE, 0, 0, 32'd99));
    dir_rows.push_back(make_row(CMD_WRITE, 1025, 0, 32'd99));
    dir_rows.push_back(make_row(CMD_WRITE, 2047, 2047, 32'hFFFF_FFFF));
    dir_rows.push_back(known(make_row(CMD_QUERY, 1, 1, 0), 32'h8000_0000, 1));
    dir_rows.push_back(known(make_row(CMD_QUERY, 0, 1, 0), 32'h8000_0000, 1));
    dir_rows.push_back(known(make_row(CMD_QUERY, 1, 5, 0), 32'h7FFF_FFFF, 2));
    dir_rows.push_back(known(make_row(CMD_QUERY, 6, 7, 0), 32'hFFFF_FFF9, 1));
    dir_rows.push_back(known(make_row(CMD_QUERY, 3, 2, 0), 32'h0, 0));
    dir_rows.push_back(known(make_row(CMD_QUERY, 2047, 3, 32'hFFFF_FFFF), 32'h0, 0));
    dir_rows.push_back(known(make_row(CMD_QUERY, 1025, 2047, 0), 32'h0, 0));
    dir_rows.push_back(known(make_row(CMD_QUERY, 1024, 2047, 0), 32'd12345, 1));
    dir_rows.push_back(known(make_row(CMD_QUERY, 1024, 1024, 0), 32'd12345, 1));
    dir_rows.push_back(make_row(CMD_QUERY, 0, 7, 0));
    dir_rows.push_back(make_row(CMD_QUERY, 2, 6, 0));
    dir_rows.push_back(known(make_row(CMD_QUERY, 2, 1, 0), 32'h0, 0));
    @(negedge clk);
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // random part in three idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 87;
        rx_idle_pct = 14;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n == 60 || n == 420) rx_hold_req = 1'b1;
      if (n == 250) begin
        while (pending_modes.size() != 0) @(negedge clk);
      end
      send_word(random_row());
    end

    wait_cnt = 0;
    while (pending_modes.size() != 0 && wait_cnt < CYCLE_LIMIT) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d writes and %0d range queries; %0d results compared, %0d missing.",
             n_writes, n_queries, n_checked, pending_modes.size());
    $display("Ran with mixed sender/receiver idling and long receiver back-pressure.");
    if (err_cnt == 0 && pending_modes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_modes.size() != 0) $error("%0d results never arrived", pending_modes.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_cell.sv
rtl/range_mode_query_core.sv
tb/testbench.sv
